// ----- rtl/voc_bsp_pkg.sv -----
package voc_bsp_pkg;

    localparam logic [31:0] RATE_DEFAULT   = 32'd11025;
    localparam logic [31:0] RATE_FLOOR     = 32'd1000;
    localparam logic [31:0] SHORT_TC_NUM   = 32'd1000000;
    localparam logic [31:0] LONG_TC_NUM    = 32'd256000000;
    localparam logic [15:0] REPEAT_FOREVER = 16'hffff;
    localparam logic [7:0]  SILENCE_LEVEL  = 8'h80;
    localparam int          HDR_DEPTH      = 12;
    localparam int          DIV_STEPS      = 32;

    // result kinds
    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_SILENCE = 2'd1;
    localparam logic [1:0] KIND_REPEAT  = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // parse phases
    localparam logic [2:0] PH_TYPE    = 3'd0;
    localparam logic [2:0] PH_LEN0    = 3'd1;
    localparam logic [2:0] PH_LEN1    = 3'd2;
    localparam logic [2:0] PH_LEN2    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    // block types
    localparam logic [7:0] BLK_TERM     = 8'd0;
    localparam logic [7:0] BLK_SOUND    = 8'd1;
    localparam logic [7:0] BLK_CONT     = 8'd2;
    localparam logic [7:0] BLK_SILENCE  = 8'd3;
    localparam logic [7:0] BLK_REP_BEG  = 8'd6;
    localparam logic [7:0] BLK_REP_END  = 8'd7;
    localparam logic [7:0] BLK_EXTENDED = 8'd8;
    localparam logic [7:0] BLK_NEWFMT   = 8'd9;

    localparam logic REG_STREAM_LENGTH = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV_A,
        ST_DIV_B,
        ST_MUL,
        ST_MUL_ADD,
        ST_EMIT,
        ST_END_BLK
    } state_t;

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_SHORT,
        DIV_LONG
    } div_op_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    function automatic logic [31:0] rate_floor(input logic [31:0] r);
        return (r < RATE_FLOOR) ? RATE_FLOOR : r;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {17'd0, a} + {1'b0, b};
        return (s[48:32] != 17'd0) ? 32'hffffffff : s[31:0];
    endfunction

endpackage

// ----- rtl/voc_bsp_div.sv -----
module voc_bsp_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  voc_bsp_pkg::div_req_t req,
    output voc_bsp_pkg::div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    // one quotient bit per cycle, restoring
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        shifted   = {acc_reg, quo_reg[31]};
        diff      = shifted - {1'b0, dvs_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (!diff[32]) begin
                acc_next = diff[31:0];
            end else begin
                acc_next = shifted[31:0];
            end
            quo_next = {quo_reg[30:0], ~diff[32]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(voc_bsp_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- rtl/voc_block_stream_parser_unit.sv -----
// Sound-block stream parser.
// Input: one raw stream byte per transfer on s_tdata. Output: result transfers,
// kind on m_tuser, the other fields packed in m_tdata. The stream length is
// written over the APB port (address 0); the user must write it only while
// the block is idle, which the block itself does not enforce. Each byte goes
// through a small sequencer: accept, decode, then the result is placed in the
// output register. A block end passes the end-of-block state and, at stream
// end, places a second result. Time constants of types 1 and 3 run one pass
// through the shared serial divider; the type 8 rate runs two passes. A repeat
// end adds a multiply state and a multiply-add state.
// s_tready is high only while the sequencer is idle; a result waiting in the
// output register does not block the next byte unless that byte produces a
// result too, in which case the sequencer waits for m_tready.
// Synchronous active-low reset clears the parse state, sets the rate to
// 11025 Hz and empties the output register. After the end-of-parse result
// all further bytes are taken and dropped until reset.
module voc_block_stream_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // [1:0] kind
    // [7:0] sample, [24:8] run_count, [56:25] segment_length,
    // [88:57] sample_rate, [89] loop_flag, [90] success, [95:91] zero
    output logic [95:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    voc_bsp_pkg::state_t  state_reg, state_next;
    voc_bsp_pkg::div_op_t div_op_reg, div_op_next;
    voc_bsp_pkg::div_req_t div_req;
    voc_bsp_pkg::div_rsp_t div_rsp;

    logic [7:0]  byte_reg, byte_next;
    logic [31:0] len_reg;
    logic [31:0] pos_reg, pos_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  bkind_reg, bkind_next;
    logic [23:0] blen_reg, blen_next;
    logic [23:0] off_reg, off_next;
    logic [7:0]  hdr_reg [voc_bsp_pkg::HDR_DEPTH];
    logic [7:0]  hdr_next [voc_bsp_pkg::HDR_DEPTH];
    logic [31:0] rate_reg, rate_next;
    logic [31:0] ext_rate_reg, ext_rate_next;
    logic        ext_valid_reg, ext_valid_next;
    logic        loop_reg, loop_next;
    logic        rep_pend_reg, rep_pend_next;
    logic [15:0] rep_times_reg, rep_times_next;
    logic [31:0] rep_mark_reg, rep_mark_next;
    logic [31:0] total_reg, total_next;
    logic        finished_reg, finished_next;
    logic [7:0]  chan_reg, chan_next;
    logic        mul_req_reg, mul_req_next;
    logic        res_req_reg, res_req_next;
    logic        end_req_reg, end_req_next;
    logic [1:0]  res_kind_reg, res_kind_next;
    logic [7:0]  res_sample_reg, res_sample_next;
    logic [16:0] res_run_reg, res_run_next;
    logic [31:0] res_seg_reg, res_seg_next;
    logic [47:0] prod_reg, prod_next;
    logic        m_tvalid_reg;
    logic [1:0]  m_tuser_reg;
    logic [95:0] m_tdata_reg;

    logic        out_free;
    logic        out_load;
    logic        cfg_write;
    logic [31:0] pos_inc;
    logic [23:0] off_inc;
    logic [23:0] full_len;
    logic [16:0] silence_cnt;
    logic [15:0] rep_count;
    logic [15:0] long_tc;
    logic [7:0]  chan_raw;
    logic        fmt_ok;
    logic [31:0] div_floor;

    voc_bsp_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == voc_bsp_pkg::REG_STREAM_LENGTH) ? len_reg : 32'd0;
    assign s_tready  = (state_reg == voc_bsp_pkg::ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tdata   = m_tdata_reg;

    assign pos_inc     = pos_reg + 32'd1;
    assign off_inc     = off_reg + 24'd1;
    assign full_len    = {byte_reg, blen_reg[15:0]};
    assign silence_cnt = {1'b0, hdr_reg[1], hdr_reg[0]} + 17'd1;
    assign rep_count   = {byte_reg, hdr_reg[0]};
    assign long_tc     = {hdr_reg[1], hdr_reg[0]};
    assign chan_raw    = byte_reg + 8'd1;
    assign fmt_ok      = (hdr_reg[6] == 8'd8) && (hdr_reg[8] == 8'd0);
    assign div_floor   = voc_bsp_pkg::rate_floor(div_rsp.quotient);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            voc_bsp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = voc_bsp_pkg::ST_STEP;
                end
            end
            voc_bsp_pkg::ST_STEP: begin
                if (div_op_next != voc_bsp_pkg::DIV_NONE) begin
                    state_next = voc_bsp_pkg::ST_DIV_A;
                end else if (mul_req_next) begin
                    state_next = voc_bsp_pkg::ST_MUL;
                end else if (res_req_next) begin
                    state_next = voc_bsp_pkg::ST_EMIT;
                end else if (end_req_next) begin
                    state_next = voc_bsp_pkg::ST_END_BLK;
                end else begin
                    state_next = voc_bsp_pkg::ST_IDLE;
                end
            end
            voc_bsp_pkg::ST_DIV_A, voc_bsp_pkg::ST_DIV_B: begin
                if (div_rsp.done) begin
                    if (state_reg == voc_bsp_pkg::ST_DIV_A &&
                        div_op_reg == voc_bsp_pkg::DIV_LONG) begin
                        state_next = voc_bsp_pkg::ST_DIV_B;
                    end else if (res_req_reg) begin
                        state_next = voc_bsp_pkg::ST_EMIT;
                    end else if (end_req_reg) begin
                        state_next = voc_bsp_pkg::ST_END_BLK;
                    end else begin
                        state_next = voc_bsp_pkg::ST_IDLE;
                    end
                end
            end
            voc_bsp_pkg::ST_MUL: begin
                state_next = voc_bsp_pkg::ST_MUL_ADD;
            end
            voc_bsp_pkg::ST_MUL_ADD: begin
                state_next = voc_bsp_pkg::ST_EMIT;
            end
            voc_bsp_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = end_req_reg ? voc_bsp_pkg::ST_END_BLK : voc_bsp_pkg::ST_IDLE;
                end
            end
            voc_bsp_pkg::ST_END_BLK: begin
                state_next = (pos_reg >= len_reg) ? voc_bsp_pkg::ST_EMIT : voc_bsp_pkg::ST_IDLE;
            end
            default: begin
                state_next = voc_bsp_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and sequencer outputs
    always_comb begin
        byte_next       = byte_reg;
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        bkind_next      = bkind_reg;
        blen_next       = blen_reg;
        off_next        = off_reg;
        hdr_next        = hdr_reg;
        rate_next       = rate_reg;
        ext_rate_next   = ext_rate_reg;
        ext_valid_next  = ext_valid_reg;
        loop_next       = loop_reg;
        rep_pend_next   = rep_pend_reg;
        rep_times_next  = rep_times_reg;
        rep_mark_next   = rep_mark_reg;
        total_next      = total_reg;
        finished_next   = finished_reg;
        chan_next       = chan_reg;
        div_op_next     = div_op_reg;
        mul_req_next    = mul_req_reg;
        res_req_next    = res_req_reg;
        end_req_next    = end_req_reg;
        res_kind_next   = res_kind_reg;
        res_sample_next = res_sample_reg;
        res_run_next    = res_run_reg;
        res_seg_next    = res_seg_reg;
        prod_next       = prod_reg;
        div_req         = '0;
        out_load        = 1'b0;

        unique case (state_reg)
            voc_bsp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    byte_next = s_tdata;
                end
            end
            voc_bsp_pkg::ST_STEP: begin
                div_op_next     = voc_bsp_pkg::DIV_NONE;
                mul_req_next    = 1'b0;
                res_req_next    = 1'b0;
                end_req_next    = 1'b0;
                res_kind_next   = voc_bsp_pkg::KIND_END;
                res_sample_next = 8'd0;
                res_run_next    = 17'd0;
                res_seg_next    = 32'd0;
                if (finished_reg) begin
                    res_req_next = 1'b0;
                end else if (pos_reg >= len_reg) begin
                    finished_next = 1'b1;
                    res_req_next  = 1'b1;
                end else begin
                    pos_next = pos_inc;
                    case (phase_reg)
                        voc_bsp_pkg::PH_TYPE: begin
                            bkind_next = byte_reg;
                            if (byte_reg == voc_bsp_pkg::BLK_TERM ||
                                ({1'b0, pos_inc} + 33'd3 > {1'b0, len_reg})) begin
                                finished_next = 1'b1;
                                res_req_next  = 1'b1;
                            end else begin
                                blen_next  = 24'd0;
                                phase_next = voc_bsp_pkg::PH_LEN0;
                            end
                        end
                        voc_bsp_pkg::PH_LEN0: begin
                            blen_next  = {16'd0, byte_reg};
                            phase_next = voc_bsp_pkg::PH_LEN1;
                        end
                        voc_bsp_pkg::PH_LEN1: begin
                            blen_next  = {8'd0, byte_reg, blen_reg[7:0]};
                            phase_next = voc_bsp_pkg::PH_LEN2;
                        end
                        voc_bsp_pkg::PH_LEN2: begin
                            blen_next = full_len;
                            if ({1'b0, pos_inc} + {9'd0, full_len} > {1'b0, len_reg}) begin
                                finished_next = 1'b1;
                                res_req_next  = 1'b1;
                            end else begin
                                off_next   = 24'd0;
                                phase_next = voc_bsp_pkg::PH_PAYLOAD;
                                if (bkind_reg == voc_bsp_pkg::BLK_REP_END) begin
                                    if (rep_pend_reg &&
                                        rep_times_reg != voc_bsp_pkg::REPEAT_FOREVER &&
                                        rep_times_reg != 16'd0 &&
                                        total_reg > rep_mark_reg) begin
                                        res_seg_next  = total_reg - rep_mark_reg;
                                        mul_req_next  = 1'b1;
                                        res_req_next  = 1'b1;
                                        res_kind_next = voc_bsp_pkg::KIND_REPEAT;
                                        res_run_next  = {1'b0, rep_times_reg};
                                    end
                                    rep_pend_next = 1'b0;
                                end
                                if (full_len == 24'd0) begin
                                    end_req_next = 1'b1;
                                end
                            end
                        end
                        default: begin
                            if (off_reg < 24'(voc_bsp_pkg::HDR_DEPTH)) begin
                                hdr_next[off_reg[3:0]] = byte_reg;
                            end
                            case (bkind_reg)
                                voc_bsp_pkg::BLK_SOUND: begin
                                    if (off_reg == 24'd0 && blen_reg >= 24'd2 &&
                                        !ext_valid_reg) begin
                                        div_op_next      = voc_bsp_pkg::DIV_SHORT;
                                        div_req.start    = 1'b1;
                                        div_req.dividend = voc_bsp_pkg::SHORT_TC_NUM;
                                        div_req.divisor  = 32'd256 - {24'd0, byte_reg};
                                    end
                                    if (off_reg >= 24'd2) begin
                                        total_next      = voc_bsp_pkg::sat_add(total_reg, 48'd1);
                                        res_req_next    = 1'b1;
                                        res_kind_next   = voc_bsp_pkg::KIND_SAMPLE;
                                        res_sample_next = byte_reg;
                                    end
                                end
                                voc_bsp_pkg::BLK_CONT: begin
                                    total_next      = voc_bsp_pkg::sat_add(total_reg, 48'd1);
                                    res_req_next    = 1'b1;
                                    res_kind_next   = voc_bsp_pkg::KIND_SAMPLE;
                                    res_sample_next = byte_reg;
                                end
                                voc_bsp_pkg::BLK_SILENCE: begin
                                    if (off_reg == 24'd2) begin
                                        if (!ext_valid_reg) begin
                                            div_op_next      = voc_bsp_pkg::DIV_SHORT;
                                            div_req.start    = 1'b1;
                                            div_req.dividend = voc_bsp_pkg::SHORT_TC_NUM;
                                            div_req.divisor  = 32'd256 - {24'd0, byte_reg};
                                        end
                                        total_next = voc_bsp_pkg::sat_add(total_reg,
                                                                          {31'd0, silence_cnt});
                                        res_req_next    = 1'b1;
                                        res_kind_next   = voc_bsp_pkg::KIND_SILENCE;
                                        res_sample_next = voc_bsp_pkg::SILENCE_LEVEL;
                                        res_run_next    = silence_cnt;
                                    end
                                end
                                voc_bsp_pkg::BLK_REP_BEG: begin
                                    if (off_reg == 24'd1) begin
                                        rep_mark_next  = total_reg;
                                        rep_times_next = rep_count;
                                        rep_pend_next  = 1'b1;
                                        if (rep_count == voc_bsp_pkg::REPEAT_FOREVER) begin
                                            loop_next = 1'b1;
                                        end
                                    end
                                end
                                voc_bsp_pkg::BLK_EXTENDED: begin
                                    if (off_reg == 24'd3) begin
                                        div_op_next      = voc_bsp_pkg::DIV_LONG;
                                        div_req.start    = 1'b1;
                                        div_req.dividend = voc_bsp_pkg::LONG_TC_NUM;
                                        div_req.divisor  = 32'd65536 - {16'd0, long_tc};
                                        // channel count zero counts as mono
                                        chan_next = (chan_raw == 8'd0) ? 8'd1 : chan_raw;
                                    end
                                end
                                voc_bsp_pkg::BLK_NEWFMT: begin
                                    if (off_reg == 24'd11 && fmt_ok && !ext_valid_reg) begin
                                        rate_next = {hdr_reg[3], hdr_reg[2], hdr_reg[1],
                                                     hdr_reg[0]};
                                    end
                                    if (off_reg >= 24'd12 && fmt_ok) begin
                                        total_next      = voc_bsp_pkg::sat_add(total_reg, 48'd1);
                                        res_req_next    = 1'b1;
                                        res_kind_next   = voc_bsp_pkg::KIND_SAMPLE;
                                        res_sample_next = byte_reg;
                                    end
                                end
                                default: begin
                                    res_req_next = 1'b0;
                                end
                            endcase
                            off_next = off_inc;
                            if (off_inc >= blen_reg) begin
                                end_req_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            voc_bsp_pkg::ST_DIV_A: begin
                if (div_rsp.done) begin
                    if (div_op_reg == voc_bsp_pkg::DIV_LONG) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                        div_req.divisor  = {24'd0, chan_reg};
                    end else begin
                        rate_next = div_floor;
                    end
                end
            end
            voc_bsp_pkg::ST_DIV_B: begin
                if (div_rsp.done) begin
                    ext_rate_next  = div_floor;
                    rate_next      = div_floor;
                    ext_valid_next = 1'b1;
                end
            end
            voc_bsp_pkg::ST_MUL: begin
                prod_next = rep_times_reg * res_seg_reg;
            end
            voc_bsp_pkg::ST_MUL_ADD: begin
                total_next = voc_bsp_pkg::sat_add(total_reg, prod_reg);
            end
            voc_bsp_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    res_req_next = 1'b0;
                end
            end
            voc_bsp_pkg::ST_END_BLK: begin
                if (bkind_reg == voc_bsp_pkg::BLK_SOUND) begin
                    ext_valid_next = 1'b0;
                end
                phase_next   = voc_bsp_pkg::PH_TYPE;
                end_req_next = 1'b0;
                if (pos_reg >= len_reg) begin
                    finished_next   = 1'b1;
                    res_req_next    = 1'b1;
                    res_kind_next   = voc_bsp_pkg::KIND_END;
                    res_sample_next = 8'd0;
                    res_run_next    = 17'd0;
                    res_seg_next    = 32'd0;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= voc_bsp_pkg::ST_IDLE;
            div_op_reg    <= voc_bsp_pkg::DIV_NONE;
            len_reg       <= 32'd0;
            pos_reg       <= 32'd0;
            phase_reg     <= voc_bsp_pkg::PH_TYPE;
            bkind_reg     <= 8'd0;
            blen_reg      <= 24'd0;
            off_reg       <= 24'd0;
            rate_reg      <= voc_bsp_pkg::RATE_DEFAULT;
            ext_rate_reg  <= 32'd0;
            ext_valid_reg <= 1'b0;
            loop_reg      <= 1'b0;
            rep_pend_reg  <= 1'b0;
            rep_times_reg <= 16'd0;
            rep_mark_reg  <= 32'd0;
            total_reg     <= 32'd0;
            finished_reg  <= 1'b0;
            mul_req_reg   <= 1'b0;
            res_req_reg   <= 1'b0;
            end_req_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_op_reg    <= div_op_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            bkind_reg     <= bkind_next;
            blen_reg      <= blen_next;
            off_reg       <= off_next;
            rate_reg      <= rate_next;
            ext_rate_reg  <= ext_rate_next;
            ext_valid_reg <= ext_valid_next;
            loop_reg      <= loop_next;
            rep_pend_reg  <= rep_pend_next;
            rep_times_reg <= rep_times_next;
            rep_mark_reg  <= rep_mark_next;
            total_reg     <= total_next;
            finished_reg  <= finished_next;
            mul_req_reg   <= mul_req_next;
            res_req_reg   <= res_req_next;
            end_req_reg   <= end_req_next;
            if (cfg_write && paddr[2] == voc_bsp_pkg::REG_STREAM_LENGTH) begin
                len_reg <= pwdata;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        byte_reg       <= byte_next;
        hdr_reg        <= hdr_next;
        chan_reg       <= chan_next;
        res_kind_reg   <= res_kind_next;
        res_sample_reg <= res_sample_next;
        res_run_reg    <= res_run_next;
        res_seg_reg    <= res_seg_next;
        prod_reg       <= prod_next;
        if (out_load) begin
            m_tuser_reg <= res_kind_reg;
            m_tdata_reg <= {5'd0,
                            (res_kind_reg == voc_bsp_pkg::KIND_END) && (total_reg != 32'd0),
                            loop_reg, rate_reg, res_seg_reg, res_run_reg, res_sample_reg};
        end
    end

`ifndef SYNTH
    a_finished_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |=> finished_reg)
        else $error("parse end flag dropped");

    a_end_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == voc_bsp_pkg::KIND_END) |-> finished_reg)
        else $error("end result without parse end");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_step_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == voc_bsp_pkg::ST_STEP) |-> $past(s_tvalid && s_tready))
        else $error("decode without accepted byte");
`endif

endmodule

// ----- verif/voc_block_stream_parser_unit_test.sv -----
`timescale 1ns / 100ps

module voc_block_stream_parser_unit_test;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  sample;
        logic [16:0] run_count;
        logic [31:0] segment_length;
        logic [31:0] sample_rate;
        logic        loop_flag;
        logic        success;
    } voc_result_t;

    // Tracks the parse state and queues the results each stream byte should produce.
    class voc_parse_scoreboard;
        logic [31:0] length_limit = 0;
        logic [31:0] pos = 0;
        logic [2:0]  phase = voc_bsp_pkg::PH_TYPE;
        logic [7:0]  blk = 0;
        logic [23:0] blen = 0;
        logic [23:0] off = 0;
        logic [7:0]  hdr [voc_bsp_pkg::HDR_DEPTH];
        logic [31:0] rate = voc_bsp_pkg::RATE_DEFAULT;
        logic [31:0] ext_rate = 0;
        logic        ext_ok = 0;
        logic        loop_seen = 0;
        logic        rep_pend = 0;
        logic [15:0] rep_times = 0;
        logic [31:0] rep_mark = 0;
        logic [31:0] total = 0;
        logic        parse_done = 0;
        voc_result_t results_due[$];
        int          errors = 0;

        function void push(logic [1:0] k, logic [7:0] s, logic [16:0] run,
                           logic [31:0] seg, logic succ);
            voc_result_t r;
            r.kind = k;
            r.sample = s;
            r.run_count = run;
            r.segment_length = seg;
            r.sample_rate = rate;
            r.loop_flag = loop_seen;
            r.success = succ;
            results_due = {results_due, r};
        endfunction

        function void end_parse();
            parse_done = 1;
            push(voc_bsp_pkg::KIND_END, 0, 0, 0, total != 0);
        endfunction

        function void grow_total(longint unsigned k);
            longint unsigned t;
            t = longint'(total) + k;
            total = (t > 64'hffffffff) ? 32'hffffffff : t[31:0];
        endfunction

        function logic [31:0] short_rate(logic [7:0] tc);
            longint unsigned r;
            r = 1000000 / (256 - tc);
            return (r < 1000) ? 32'd1000 : r[31:0];
        endfunction

        function logic [31:0] long_rate(logic [15:0] tc, logic [7:0] ch);
            longint unsigned r;
            longint unsigned c;
            c = (ch == 0) ? 1 : ch;
            r = 256000000 / (65536 - tc) / c;
            return (r < 1000) ? 32'd1000 : r[31:0];
        endfunction

        function void add_sample(logic [7:0] b);
            grow_total(1);
            push(voc_bsp_pkg::KIND_SAMPLE, b, 0, 0, 0);
        endfunction

        function void close_block();
            if (blk == voc_bsp_pkg::BLK_SOUND)
                ext_ok = 0;
            phase = voc_bsp_pkg::PH_TYPE;
            if (pos >= length_limit)
                end_parse();
        endfunction

        function void payload(logic [7:0] b);
            logic [23:0] o;
            logic [16:0] cnt;
            logic        fmt_ok;
            o = off;
            if (o < voc_bsp_pkg::HDR_DEPTH)
                hdr[o] = b;
            case (blk)
                voc_bsp_pkg::BLK_SOUND: begin
                    if (o == 0 && blen >= 2 && !ext_ok)
                        rate = short_rate(b);
                    if (o >= 2)
                        add_sample(b);
                end
                voc_bsp_pkg::BLK_CONT: add_sample(b);
                voc_bsp_pkg::BLK_SILENCE: begin
                    if (o == 2) begin
                        cnt = {hdr[1], hdr[0]} + 17'd1;
                        if (!ext_ok)
                            rate = short_rate(b);
                        grow_total(cnt);
                        push(voc_bsp_pkg::KIND_SILENCE, voc_bsp_pkg::SILENCE_LEVEL, cnt, 0, 0);
                    end
                end
                voc_bsp_pkg::BLK_REP_BEG: begin
                    if (o == 1) begin
                        rep_mark = total;
                        rep_times = {hdr[1], hdr[0]};
                        rep_pend = 1;
                        if (rep_times == voc_bsp_pkg::REPEAT_FOREVER)
                            loop_seen = 1;
                    end
                end
                voc_bsp_pkg::BLK_EXTENDED: begin
                    if (o == 3) begin
                        ext_rate = long_rate({hdr[1], hdr[0]}, b + 8'd1);
                        rate = ext_rate;
                        ext_ok = 1;
                    end
                end
                voc_bsp_pkg::BLK_NEWFMT: begin
                    // header entries 6 and 8 are always written by the time they matter
                    fmt_ok = (o >= 11) && hdr[6] == 8 && hdr[8] == 0;
                    if (o == 11 && fmt_ok && !ext_ok)
                        rate = {hdr[3], hdr[2], hdr[1], hdr[0]};
                    if (o >= 12 && fmt_ok)
                        add_sample(b);
                end
                default: ;
            endcase
            off = o + 24'd1;
            if (off >= blen)
                close_block();
        endfunction

        function void note_byte(logic [7:0] b);
            logic [31:0] seg;
            if (parse_done)
                return;
            if (pos >= length_limit) begin
                end_parse();
                return;
            end
            pos++;
            case (phase)
                voc_bsp_pkg::PH_TYPE: begin
                    blk = b;
                    if (b == voc_bsp_pkg::BLK_TERM ||
                        {1'b0, pos} + 33'd3 > {1'b0, length_limit}) begin
                        end_parse();
                    end else begin
                        blen = 0;
                        phase = voc_bsp_pkg::PH_LEN0;
                    end
                end
                voc_bsp_pkg::PH_LEN0, voc_bsp_pkg::PH_LEN1: begin
                    blen[8*(phase-1) +: 8] = b;
                    phase++;
                end
                voc_bsp_pkg::PH_LEN2: begin
                    blen[23:16] = b;
                    if ({1'b0, pos} + {9'd0, blen} > {1'b0, length_limit}) begin
                        end_parse();
                    end else begin
                        off = 0;
                        phase = voc_bsp_pkg::PH_PAYLOAD;
                        if (blk == voc_bsp_pkg::BLK_REP_END) begin
                            if (rep_pend && rep_times != voc_bsp_pkg::REPEAT_FOREVER &&
                                    rep_times != 0 && total > rep_mark) begin
                                seg = total - rep_mark;
                                grow_total(longint'(rep_times) * seg);
                                push(voc_bsp_pkg::KIND_REPEAT, 0, rep_times, seg, 0);
                            end
                            rep_pend = 0;
                        end
                        if (blen == 0)
                            close_block();
                    end
                end
                default: payload(b);
            endcase
        endfunction

        function void check_result(voc_result_t got);
            voc_result_t want;
            if (results_due.size() == 0) begin
                $error("unexpected result transfer, kind %0d", got.kind);
                errors++;
                return;
            end
            want = results_due.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.sample !== want.sample) begin
                $error("sample: expected %0d, got %0d", want.sample, got.sample);
                errors++;
            end
            if (got.run_count !== want.run_count) begin
                $error("run_count: expected %0d, got %0d", want.run_count, got.run_count);
                errors++;
            end
            if (got.segment_length !== want.segment_length) begin
                $error("segment_length: expected %0d, got %0d",
                       want.segment_length, got.segment_length);
                errors++;
            end
            if (got.sample_rate !== want.sample_rate) begin
                $error("sample_rate: expected %0d, got %0d", want.sample_rate, got.sample_rate);
                errors++;
            end
            if (got.loop_flag !== want.loop_flag) begin
                $error("loop_flag: expected %0d, got %0d", want.loop_flag, got.loop_flag);
                errors++;
            end
            if (got.success !== want.success) begin
                $error("success: expected %0d, got %0d", want.success, got.success);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [1:0]  m_tuser;
    logic [95:0] m_tdata;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    voc_block_stream_parser_unit dut (.*);

    always #5 aclk = ~aclk;

    voc_parse_scoreboard sb = new();
    int bytes_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int cfg_errors = 0;
    bit hold_done = 0;
    logic [7:0] block_bytes[$];

    // monitor: inputs change at the falling edge, so pre-edge values are stable here
    always @(posedge aclk) begin
        voc_result_t r;
        if (s_tvalid && s_tready)
            sb.note_byte(s_tdata);
        if (m_tvalid && m_tready) begin
            r.kind = m_tuser;
            r.sample = m_tdata[7:0];
            r.run_count = m_tdata[24:8];
            r.segment_length = m_tdata[56:25];
            r.sample_rate = m_tdata[88:57];
            r.loop_flag = m_tdata[89];
            r.success = m_tdata[90];
            sb.check_result(r);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: rotates through always-ready, random and mostly-stalled ready patterns, plus one long hold-off
    initial begin
        int cyc;
        cyc = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            cyc++;
            if (!hold_done && bytes_sent >= 700) begin
                hold_done = 1;
                m_tready <= 0;
                repeat (400) @(negedge aclk);
            end else begin
                case ((cyc / 64) % 3)
                    0: m_tready <= 1;
                    1: m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        block_bytes = {block_bytes, b};
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_block();
        while (block_bytes.size() > 0)
            send_byte(block_bytes.pop_front());
    endtask

    task automatic drain();
        s_tvalid <= 0;
        burst_left = 0;
        while (sb.results_due.size() != 0)
            @(negedge aclk);
        // bytes with no result may still be in the divider
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_length(input logic [31:0] v);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {voc_bsp_pkg::REG_STREAM_LENGTH, 2'b00};
        pwdata <= v;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        sb.length_limit = v;
        @(negedge aclk);
        pwrite <= 0;
        penable <= 0;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        if (prdata !== v) begin
            $error("stream_length readback: expected %0h, got %0h", v, prdata);
            cfg_errors++;
        end
        @(negedge aclk);
        psel <= 0;
        penable <= 0;
    endtask

    task automatic add_header(input logic [7:0] t, input int len);
        queue_byte(t);
        queue_byte(len[7:0]);
        queue_byte(len[15:8]);
        queue_byte(len[23:16]);
    endtask

    task automatic build_random_block();
        int len;
        int sel;
        logic [15:0] cnt;
        sel = $urandom_range(0, 19);
        case (sel)
            0, 1, 2: begin
                len = $urandom_range(0, 24);
                add_header(voc_bsp_pkg::BLK_SOUND, len);
                for (int i = 0; i < len; i++)
                    queue_byte((i == 0 && $urandom_range(0, 3) == 0) ?
                               ($urandom_range(0, 1) ? 8'hff : 8'h00) :
                               8'($urandom));
            end
            3, 4, 5, 6: begin
                len = $urandom_range(0, 24);
                add_header(voc_bsp_pkg::BLK_CONT, len);
                for (int i = 0; i < len; i++)
                    queue_byte(8'($urandom));
            end
            7, 8: begin
                len = $urandom_range(3, 4);
                add_header(voc_bsp_pkg::BLK_SILENCE, len);
                cnt = $urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom_range(0, 300));
                queue_byte(cnt[7:0]);
                queue_byte(cnt[15:8]);
                for (int i = 2; i < len; i++)
                    queue_byte(8'($urandom));
            end
            9, 10: begin
                len = $urandom_range(2, 3);
                add_header(voc_bsp_pkg::BLK_REP_BEG, len);
                case ($urandom_range(0, 4))
                    0: cnt = voc_bsp_pkg::REPEAT_FOREVER;
                    1: cnt = 0;
                    2: cnt = 16'($urandom);
                    default: cnt = $urandom_range(1, 4);
                endcase
                queue_byte(cnt[7:0]);
                queue_byte(cnt[15:8]);
                for (int i = 2; i < len; i++)
                    queue_byte(8'($urandom));
            end
            11, 12: begin
                len = $urandom_range(0, 2);
                add_header(voc_bsp_pkg::BLK_REP_END, len);
                for (int i = 0; i < len; i++)
                    queue_byte(8'($urandom));
            end
            13, 14: begin
                len = $urandom_range(4, 5);
                add_header(voc_bsp_pkg::BLK_EXTENDED, len);
                for (int i = 0; i < len; i++)
                    queue_byte(8'($urandom));
            end
            15, 16, 17: begin
                len = $urandom_range(12, 28);
                add_header(voc_bsp_pkg::BLK_NEWFMT, len);
                for (int i = 0; i < len; i++) begin
                    if (i == 6)
                        queue_byte($urandom_range(0, 5) ? 8'd8 : 8'($urandom));
                    else if (i == 8)
                        queue_byte($urandom_range(0, 5) ? 8'd0 : 8'($urandom));
                    else
                        queue_byte(8'($urandom));
                end
            end
            default: begin
                len = $urandom_range(0, 6);
                add_header($urandom_range(0, 1) ? 8'($urandom_range(10, 255)) :
                           8'($urandom_range(4, 5)), len);
                for (int i = 0; i < len; i++)
                    queue_byte(8'($urandom));
            end
        endcase
    endtask

    initial begin
        int ending;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        write_length(32'hffffffff);

        // extended rate at its top with wrapped channel count, then a sound block
        // whose time constant is overridden, then the longest silence run
        add_header(voc_bsp_pkg::BLK_EXTENDED, 4);
        block_bytes = {block_bytes, 8'hff, 8'hff, 8'h00, 8'hff};
        add_header(voc_bsp_pkg::BLK_SOUND, 3);
        block_bytes = {block_bytes, 8'h00, 8'h00, 8'hff};
        add_header(voc_bsp_pkg::BLK_SILENCE, 3);
        block_bytes = {block_bytes, 8'hff, 8'hff, 8'h00};
        send_block();

        while (bytes_sent < 850) begin
            build_random_block();
            send_block();
        end
        drain();
        write_length(bytes_sent + 5000);
        while (bytes_sent < 1650) begin
            build_random_block();
            send_block();
        end
        drain();

        ending = $urandom_range(0, 4);
        case (ending)
            0: queue_byte(voc_bsp_pkg::BLK_TERM);
            1: begin
                // type byte with fewer than three bytes left
                write_length(bytes_sent + 3);
                queue_byte(voc_bsp_pkg::BLK_CONT);
            end
            2: begin
                write_length(bytes_sent + 10);
                block_bytes = {voc_bsp_pkg::BLK_CONT, 8'hff, 8'hff, 8'hff};
            end
            3: begin
                // last block ends exactly at the stream end
                write_length(bytes_sent + 6);
                block_bytes = {voc_bsp_pkg::BLK_CONT, 8'd2, 8'd0, 8'd0, 8'($urandom),
                               8'($urandom)};
            end
            default: write_length(32'd0);
        endcase
        repeat (5)
            queue_byte(8'($urandom));
        send_block();
        drain();

        if (sb.errors == 0 && cfg_errors == 0 && sb.results_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
